// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/crc32fac_pkg.sv -----
// Types, constants and the CRC byte update shared by the CRC-32 frame block.
package crc32fac_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [2:0] TRAIL_LEN = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_MODE_CHECK = 2'd0;
  localparam logic [1:0] REG_START_VALUE = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       is_verdict;
    logic       crc_ok;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_APPEND_LAST,
    CMD_VERDICT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    logic [31:0] crc;
    logic        ok;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/crc32fac_front.sv -----
// Front end: accepts frame bytes, runs the CRC and the check-mode delay line, queues commands.
module crc32fac_front import crc32fac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  q_status_t   q_status,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic        mode_r, mode_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] run_r, run_nxt;
  logic [31:0] held_r, held_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic        fire;
  logic [7:0]  crc_in;
  logic [31:0] crc_upd;
  logic [31:0] run_adv;
  logic [31:0] held_shift;
  logic [2:0]  cnt_inc;

  assign in_ready = !q_status.full;
  assign fire = in_valid && in_ready;

  assign crc_in = mode_r ? held_r[7:0] : in_data.data_byte;
  assign crc_upd = crc_byte(run_r, crc_in);
  assign run_adv = (cnt_r == TRAIL_LEN) ? crc_upd : run_r;
  assign held_shift = {in_data.data_byte, held_r[31:8]};
  assign cnt_inc = (cnt_r == TRAIL_LEN) ? cnt_r : cnt_r + 3'd1;

  always_comb begin
    mode_nxt = mode_r;
    start_nxt = start_r;
    run_nxt = run_r;
    held_nxt = held_r;
    cnt_nxt = cnt_r;
    q_push = 1'b0;
    q_entry.kind = CMD_BYTE;
    q_entry.data_byte = in_data.data_byte;
    q_entry.crc = ~crc_upd;
    q_entry.ok = 1'b0;
    if (cfg_wr_en && (cfg_index == REG_MODE_CHECK || cfg_index == REG_START_VALUE)) begin
      if (cfg_index == REG_MODE_CHECK) begin
        mode_nxt = cfg_wdata[0];
      end else begin
        start_nxt = cfg_wdata;
      end
      run_nxt = (cfg_index == REG_START_VALUE) ? ~cfg_wdata : ~start_r;
      held_nxt = '0;
      cnt_nxt = '0;
    end else if (fire) begin
      if (!mode_r) begin
        q_push = 1'b1;
        q_entry.kind = in_data.last_byte ? CMD_APPEND_LAST : CMD_BYTE;
        run_nxt = in_data.last_byte ? ~start_r : crc_upd;
      end else if (in_data.last_byte) begin
        q_push = 1'b1;
        q_entry.kind = CMD_VERDICT;
        q_entry.ok = (cnt_inc == TRAIL_LEN) && (~run_adv == held_shift);
        run_nxt = ~start_r;
        held_nxt = '0;
        cnt_nxt = '0;
      end else begin
        run_nxt = run_adv;
        held_nxt = held_shift;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      start_r <= '0;
      run_r <= '1;
      held_r <= '0;
      cnt_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      start_r <= start_nxt;
      run_r <= run_nxt;
      held_r <= held_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/crc32fac_queue.sv -----
// Small register queue of commands between the front end and the back end.
module crc32fac_queue import crc32fac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign status.empty = (cnt_r == '0);
  assign status.full = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/crc32fac_back.sv -----
// Back end: expands queued commands into output words and holds the output register.
module crc32fac_back import crc32fac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  q_entry_t  q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic        valid_r, valid_nxt;
  out_word_t   word_r, word_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        load;

  assign load = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data = word_r;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt = word_r;
    crc_nxt = crc_r;
    rem_nxt = rem_r;
    q_pop = 1'b0;
    if (load) begin
      if (rem_r != '0) begin
        valid_nxt = 1'b1;
        word_nxt = '{out_byte: crc_r[7:0], out_last: (rem_r == 3'd1),
                     is_verdict: 1'b0, crc_ok: 1'b0};
        crc_nxt = {8'd0, crc_r[31:8]};
        rem_nxt = rem_r - 3'd1;
      end else if (!q_status.empty) begin
        q_pop = 1'b1;
        valid_nxt = 1'b1;
        case (q_head.kind)
          CMD_VERDICT: begin
            word_nxt = '{out_byte: 8'd0, out_last: 1'b1, is_verdict: 1'b1,
                         crc_ok: q_head.ok};
          end
          CMD_APPEND_LAST: begin
            word_nxt = '{out_byte: q_head.data_byte, out_last: 1'b0,
                         is_verdict: 1'b0, crc_ok: 1'b0};
            crc_nxt = q_head.crc;
            rem_nxt = TRAIL_LEN;
          end
          default: begin
            word_nxt = '{out_byte: q_head.data_byte, out_last: 1'b0,
                         is_verdict: 1'b0, crc_ok: 1'b0};
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    crc_r <= crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- rtl/core/crc32_frame_append_check.sv -----
// Top level of the CRC-32 frame append and check block.
// Frame bytes enter on the in_ channel (valid/ready), one word per byte, with
// last_byte on the final byte of a frame. Results leave on the out_ channel.
// In append mode every byte is echoed, and the last byte is followed by the
// four CRC bytes, least significant first, the fourth marked out_last. In
// check mode the final four bytes of a frame are compared, little-endian,
// against the CRC of the bytes before them and one verdict word is produced.
// One byte is accepted per cycle while the queue is not full; an append-mode
// frame of N bytes yields N + 4 output words, so the four-entry command queue
// between the CRC front end and the output sequencer sets how long input
// keeps flowing during CRC bytes. When the receiver stalls, the output word
// holds and the queue fills; in_ready falls only when the queue is full.
// Reset is synchronous: mode returns to append, the start value to zero, and
// the queue and output are emptied. The cfg_ port writes register 0 (mode) or
// 1 (start value) and restarts the frame; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module crc32_frame_append_check import crc32fac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  q_entry_t  q_entry;
  q_entry_t  q_head;

  crc32fac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  crc32fac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  crc32fac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- rtl/core/crc32fac_checker.sv -----
// Port-level assertions for the CRC-32 frame block and their binding.
`include "assert_macros.svh"

module crc32fac_checker import crc32fac_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output word changed")
  `ASSERT_CLK(a_verdict_form, clk, rst_n, out_valid && out_data.is_verdict |-> out_data.out_last && out_data.out_byte == 8'd0, "verdict word is not a final word with zero byte")
  `ASSERT_CLK(a_byte_no_ok, clk, rst_n, out_valid && !out_data.is_verdict |-> !out_data.crc_ok, "byte word carries a check result")
  `ASSERT_CLK_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind crc32_frame_append_check crc32fac_checker u_checker (.*);
